// ----- src/mbrtu_pkg.sv -----
// shared types, constants and the crc step for the modbus rtu request framer
// no dependencies
package mbrtu_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned CRC_SPAN  = 6;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] ADDR_BIAS = 16'h0001;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t IDX_LAST    = idx_t'(FRAME_LEN - 1);
    localparam idx_t IDX_CRC_END = idx_t'(CRC_SPAN);

    // classified request, the six header bytes in word form
    typedef struct packed {
        logic [7:0]  slave_id;
        logic [7:0]  func_code;
        logic [15:0] addr;
        logic [15:0] word;
    } frame_hdr_t;

    // one byte through the reflected crc-16, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/mbrtu_front.sv -----
// front end: takes request items and turns them into frame headers
// depends on mbrtu_pkg
module mbrtu_front
(
    input  logic                    start,
    input  logic                    queue_full,
    input  logic                    op,
    input  logic [7:0]              slave_id,
    input  logic [7:0]              func_code,
    input  logic [15:0]             start_address,
    input  logic [15:0]             second_word,
    output logic                    push,
    output mbrtu_pkg::frame_hdr_t   hdr
);

    logic [15:0] quantity;

    assign push     = start && !queue_full;
    // read quantity, end minus start plus one, wrapping
    assign quantity = second_word - start_address + mbrtu_pkg::ADDR_BIAS;

    always_comb
    begin
        hdr.slave_id  = slave_id;
        hdr.func_code = func_code;
        hdr.addr      = start_address - mbrtu_pkg::ADDR_BIAS;
        unique case (op)
            mbrtu_pkg::OP_WRITE: hdr.word = second_word;
            mbrtu_pkg::OP_READ:  hdr.word = quantity;
            default:             hdr.word = quantity;
        endcase
    end

endmodule

// ----- src/mbrtu_queue.sv -----
// short queue of frame headers between front and back
// depends on mbrtu_pkg
module mbrtu_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mbrtu_pkg::frame_hdr_t   push_data,
    input  logic                    pop,
    output mbrtu_pkg::frame_hdr_t   pop_data,
    output logic                    full,
    output logic                    empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mbrtu_pkg::frame_hdr_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
`endif

endmodule

// ----- src/mbrtu_back.sv -----
// back end: sends one header as eight frame bytes with running crc
// depends on mbrtu_pkg
module mbrtu_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    queue_empty,
    input  mbrtu_pkg::frame_hdr_t   queue_data,
    output logic                    pop,
    output logic                    strobe,
    output logic [7:0]              frame_byte,
    output logic                    last
);

    logic                   active_reg, active_next;
    mbrtu_pkg::idx_t        idx_reg, idx_next;
    mbrtu_pkg::frame_hdr_t  hdr_reg, hdr_next;
    logic [15:0]            crc_reg, crc_next;
    logic                   at_last;

    assign at_last = (idx_reg == mbrtu_pkg::IDX_LAST);
    assign strobe  = active_reg;
    assign last    = active_reg && at_last;
    // fetch a new header when idle or on the final byte
    assign pop     = !queue_empty && (!active_reg || at_last);

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    frame_byte = hdr_reg.slave_id;
            3'd1:    frame_byte = hdr_reg.func_code;
            3'd2:    frame_byte = hdr_reg.addr[15:8];
            3'd3:    frame_byte = hdr_reg.addr[7:0];
            3'd4:    frame_byte = hdr_reg.word[15:8];
            3'd5:    frame_byte = hdr_reg.word[7:0];
            3'd6:    frame_byte = crc_reg[7:0];
            default: frame_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        hdr_next    = hdr_reg;
        crc_next    = crc_reg;
        if (active_reg && idx_reg < mbrtu_pkg::IDX_CRC_END)
        begin
            crc_next = mbrtu_pkg::crc16_byte(crc_reg, frame_byte);
        end
        if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (active_reg && at_last)
        begin
            active_next = 1'b0;
        end
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            hdr_next    = queue_data;
            crc_next    = mbrtu_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        crc_reg <= crc_next;
    end

`ifndef SYNTHESIS
    a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && idx_reg == $past(idx_reg) + 1'b1))
        else $error("frame bytes not contiguous");

    a_frame_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(pop) |-> (strobe && idx_reg == '0))
        else $error("frame does not start at byte zero");
`endif

endmodule

// ----- src/modbus_rtu_request_framer.sv -----
// top level of the modbus rtu request framer
// depends on mbrtu_pkg, mbrtu_front, mbrtu_queue, mbrtu_back

// each accepted request item (start high while busy is low) produces one
// eight-byte modbus rtu request frame: slave id, function code, register
// address minus one (high byte first), quantity for a read or value for a
// write (high byte first), then the crc-16 over the first six bytes, low
// byte first. bytes come out one per cycle with strobe high, last marks
// the eighth byte; the receiver must take every byte as it is shown. the
// byte serializer sets the rate, frames running back to back. an item
// accepted while the serializer is idle is registered in the queue, then
// in the serializer, before it shows. a queue of QUEUE_DEPTH headers sits
// between the request side and the serializer, so up to QUEUE_DEPTH items
// may be taken ahead; busy is high exactly while that queue is full.
// the crc advances one byte per cycle as bytes 0 to 5 go out.
module modbus_rtu_request_framer
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  slave_id,
    input  logic [7:0]  func_code,
    input  logic [15:0] start_address,
    input  logic [15:0] second_word,
    output logic        strobe,
    output logic [7:0]  frame_byte,
    output logic        last
);

    // header path between the three parts
    mbrtu_pkg::frame_hdr_t push_hdr;
    mbrtu_pkg::frame_hdr_t pop_hdr;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_empty;

    assign busy = queue_full;

    // classify the request and build the header words
    mbrtu_front u_front
    (
        .start         (start),
        .queue_full    (queue_full),
        .op            (op),
        .slave_id      (slave_id),
        .func_code     (func_code),
        .start_address (start_address),
        .second_word   (second_word),
        .push          (push),
        .hdr           (push_hdr)
    );

    // decouples item intake from byte output
    mbrtu_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_hdr),
        .pop       (pop),
        .pop_data  (pop_hdr),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // serialize bytes and append the crc
    mbrtu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_hdr),
        .pop         (pop),
        .strobe      (strobe),
        .frame_byte  (frame_byte),
        .last        (last)
    );

`ifndef SYNTHESIS
    a_last_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> $past(strobe, 7))
        else $error("last byte without a full frame before it");
`endif

endmodule

// ----- test/modbus_rtu_request_framer_tb.sv -----
// self-checking testbench for modbus_rtu_request_framer: directed frames then random requests
// predicts every frame byte from the request fields or a hand-written frame; depends on mbrtu_pkg and the framer rtl
`timescale 1ns / 100ps

module modbus_rtu_request_framer_tb;

    // common function codes, used to shape the stimulus
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

    localparam int RANDOM_REQUESTS = 470;
    localparam int BLOCK_LEN       = 40;
    localparam int MAX_GAP         = 13;
    localparam int WATCHDOG_LIMIT  = 400;
    localparam int DRAIN_CYCLES    = 24;
    localparam int MAX_REPORTS     = 10;
    localparam int DIRECTED_ROWS   = 16;

    // one directed request; frame_known marks rows with a hand-written frame
    typedef struct {
        logic        op;
        logic [7:0]  slave_id;
        logic [7:0]  func_code;
        logic [15:0] start_address;
        logic [15:0] second_word;
        logic        frame_known;
        logic [63:0] frame;
    } request_row_t;

    typedef struct {
        logic [7:0] value;
        logic       is_last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        op = mbrtu_pkg::OP_READ;
    logic [7:0]  slave_id = 8'h00;
    logic [7:0]  func_code = 8'h00;
    logic [15:0] start_address = 16'h0000;
    logic [15:0] second_word = 16'h0000;
    logic        strobe;
    logic [7:0]  frame_byte;
    logic        last;

    // hand-written frame that travels with the current item
    logic        row_frame_known = 1'b0;
    logic [63:0] row_frame = 64'h0;

    // sender idling control
    logic        sender_no_idle = 1'b0;

    frame_byte_t awaited_bytes [$];
    int          mismatch_count = 0;
    int          read_frames = 0;
    int          write_frames = 0;
    int          bytes_checked = 0;
    int          idle_cycles = 0;

    // directed table: the three known frames are textbook modbus requests
    request_row_t directed_rows [DIRECTED_ROWS] = '{
        '{mbrtu_pkg::OP_READ,  8'h01, FC_READ_HOLDING, 16'h0001, 16'h0001, 1'b1,
          64'h01030000_0001840A},
        '{mbrtu_pkg::OP_READ,  8'h01, FC_READ_HOLDING, 16'h0001, 16'h000A, 1'b1,
          64'h01030000_000AC5CD},
        '{mbrtu_pkg::OP_READ,  8'h11, FC_READ_HOLDING, 16'h006C, 16'h006E, 1'b1,
          64'h1103006B_00037687},
        // address zero wraps to ffff
        '{mbrtu_pkg::OP_READ,  8'h01, FC_READ_HOLDING, 16'h0000, 16'h0000, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_READ,  8'hFF, FC_READ_INPUT,   16'hFFFF, 16'hFFFF, 1'b0, 64'h0},
        // end below start, quantity wraps
        '{mbrtu_pkg::OP_READ,  8'h02, FC_READ_HOLDING, 16'h1000, 16'h0FFF, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_READ,  8'h03, FC_READ_HOLDING, 16'hFFFF, 16'h0000, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_WRITE, 8'h00, 8'h00,           16'h0000, 16'h0000, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_WRITE, 8'hFF, 8'hFF,           16'hFFFF, 16'hFFFF, 1'b0, 64'h0},
        // function code disagrees with op, layout follows op
        '{mbrtu_pkg::OP_WRITE, 8'h05, FC_READ_HOLDING, 16'h0001, 16'h1234, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_READ,  8'h05, FC_WRITE_SINGLE, 16'h0001, 16'h1234, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_WRITE, 8'h01, FC_WRITE_SINGLE, 16'h0001, 16'h8000, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_READ,  8'hFF, 8'hFF,           16'h8000, 16'h7FFF, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_WRITE, 8'h01, FC_WRITE_SINGLE, 16'h0001, 16'h0000, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_READ,  8'h55, FC_READ_INPUT,   16'hAAAA, 16'h5555, 1'b0, 64'h0},
        '{mbrtu_pkg::OP_WRITE, 8'hAA, 8'h55,           16'h5555, 16'hAAAA, 1'b0, 64'h0}
    };

    modbus_rtu_request_framer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .slave_id      (slave_id),
        .func_code     (func_code),
        .start_address (start_address),
        .second_word   (second_word),
        .strobe        (strobe),
        .frame_byte    (frame_byte),
        .last          (last)
    );

    always #5 clk = ~clk;

    // whole request frame, byte 0 in the top eight bits
    function automatic logic [63:0] build_request_frame(
        input logic        is_write,
        input logic [7:0]  sid,
        input logic [7:0]  fc,
        input logic [15:0] first_reg,
        input logic [15:0] word_in
    );
        logic [15:0] wire_addr;
        logic [15:0] data_word;
        logic [15:0] crc;
        logic [47:0] header;
        wire_addr = first_reg - 16'd1;
        // read carries a quantity, write carries the value as is
        if (is_write == mbrtu_pkg::OP_WRITE)
        begin
            data_word = word_in;
        end
        else
        begin
            data_word = word_in - first_reg + 16'd1;
        end
        header = {sid, fc, wire_addr, data_word};
        crc = 16'hFFFF;
        for (int n = 0; n < 6; n++)
        begin
            crc = crc ^ {8'h00, header[47 - 8 * n -: 8]};
            for (int k = 0; k < 8; k++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
            end
        end
        // crc goes out low byte first
        return {header, crc[7:0], crc[15:8]};
    endfunction

    // present one item, after a random gap unless sender_no_idle is set, and hold it until it is taken
    task automatic send_request(
        input logic        f_op,
        input logic [7:0]  f_sid,
        input logic [7:0]  f_fc,
        input logic [15:0] f_start,
        input logic [15:0] f_second,
        input logic        f_known,
        input logic [63:0] f_frame
    );
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        op              <= f_op;
        slave_id        <= f_sid;
        func_code       <= f_fc;
        start_address   <= f_start;
        second_word     <= f_second;
        row_frame_known <= f_known;
        row_frame       <= f_frame;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // random request, mostly well-formed reads and writes with random content
    task automatic send_random_request();
        logic        r_op;
        logic [7:0]  r_fc;
        logic [15:0] r_start;
        logic [15:0] r_second;
        r_op = $urandom_range(0, 1) ? mbrtu_pkg::OP_WRITE : mbrtu_pkg::OP_READ;
        case ($urandom_range(0, 7))
            0: r_start = 16'h0000;
            1: r_start = 16'h0001;
            2: r_start = 16'hFFFF;
            default: r_start = 16'($urandom_range(0, 16'hFFFF));
        endcase
        if (r_op == mbrtu_pkg::OP_READ)
        begin
            r_fc = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
            // sensible quantity of 1 to 125, otherwise any end address
            if ($urandom_range(0, 1))
            begin
                r_second = r_start + 16'($urandom_range(0, 124));
            end
            else
            begin
                r_second = 16'($urandom_range(0, 16'hFFFF));
            end
        end
        else
        begin
            r_fc = FC_WRITE_SINGLE;
            r_second = 16'($urandom_range(0, 16'hFFFF));
        end
        // some function codes are arbitrary bytes
        if ($urandom_range(0, 9) < 3)
        begin
            r_fc = 8'($urandom_range(0, 255));
        end
        send_request(r_op, 8'($urandom_range(0, 255)), r_fc, r_start, r_second, 1'b0, 64'h0);
    endtask

    // acceptance queues the expected bytes, each strobe is checked against the oldest
    always @(posedge clk)
    begin
        logic [63:0] expected_frame;
        frame_byte_t item;
        frame_byte_t oldest;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (row_frame_known)
                begin
                    expected_frame = row_frame;
                end
                else
                begin
                    expected_frame = build_request_frame(op, slave_id, func_code,
                                                         start_address, second_word);
                end
                for (int k = 0; k < mbrtu_pkg::FRAME_LEN; k++)
                begin
                    item.value   = expected_frame[63 - 8 * k -: 8];
                    item.is_last = (k == mbrtu_pkg::FRAME_LEN - 1);
                    awaited_bytes.push_back(item);
                end
                if (op == mbrtu_pkg::OP_WRITE)
                begin
                    write_frames++;
                end
                else
                begin
                    read_frames++;
                end
            end
            if (strobe)
            begin
                if (awaited_bytes.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("ERROR: byte %02h last %b with nothing awaited",
                                 frame_byte, last);
                    end
                    mismatch_count++;
                end
                else
                begin
                    oldest = awaited_bytes.pop_front();
                    bytes_checked++;
                    if (frame_byte !== oldest.value || last !== oldest.is_last)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                        begin
                            $display("ERROR: byte %0d expected %02h last %b, got %02h last %b",
                                     bytes_checked, oldest.value, oldest.is_last,
                                     frame_byte, last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item taken and no byte shown
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles", idle_cycles);
                $display("modbus_rtu_request_framer verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back for the first few
        sender_no_idle = 1'b1;
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (r == 4)
            begin
                sender_no_idle = 1'b0;
            end
            send_request(directed_rows[r].op, directed_rows[r].slave_id,
                         directed_rows[r].func_code, directed_rows[r].start_address,
                         directed_rows[r].second_word, directed_rows[r].frame_known,
                         directed_rows[r].frame);
        end

        // random part in blocks, every third block with no gaps at all
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % BLOCK_LEN == 0)
            begin
                sender_no_idle = ((i / BLOCK_LEN) % 3 == 1);
            end
            // halfway the sender holds off until the framer has drained
            if (i == RANDOM_REQUESTS / 2)
            begin
                start <= 1'b0;
                while (awaited_bytes.size() != 0)
                begin
                    @(posedge clk);
                end
                @(posedge clk);
            end
            send_random_request();
        end
        start <= 1'b0;

        while (awaited_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_bytes.size() != 0)
        begin
            $display("ERROR: %0d frame bytes never arrived", awaited_bytes.size());
            mismatch_count++;
        end
        $display("covered %0d read and %0d write requests, %0d frame bytes compared",
                 read_frames, write_frames, bytes_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("modbus_rtu_request_framer verification clean");
        end
        else
        begin
            $display("modbus_rtu_request_framer verification failed");
        end
        $finish;
    end

endmodule

// ----- modbus_rtu_request_framer.f -----
src/mbrtu_pkg.sv
src/mbrtu_front.sv
src/mbrtu_queue.sv
src/mbrtu_back.sv
src/modbus_rtu_request_framer.sv
test/modbus_rtu_request_framer_tb.sv
